// ----- hw/rtl/vmmio_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the virtio-mmio register front end.
package vmmio_pkg;

    // Width of the register index on the configuration channel.
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_BASE = 8'd0,
        CFG_READ_ONLY   = 8'd1,
        CFG_CAPACITY    = 8'd2,
        CFG_VENDOR      = 8'd3
    } cfg_idx_t;

    // Register offsets inside the window (low byte; the upper offset bits are zero).
    localparam logic [7:0] OFF_MAGIC          = 8'h00;
    localparam logic [7:0] OFF_VERSION        = 8'h04;
    localparam logic [7:0] OFF_DEVICE_ID      = 8'h08;
    localparam logic [7:0] OFF_VENDOR_ID      = 8'h0C;
    localparam logic [7:0] OFF_DEV_FEAT       = 8'h10;
    localparam logic [7:0] OFF_DEV_FEAT_SEL   = 8'h14;
    localparam logic [7:0] OFF_DRV_FEAT       = 8'h20;
    localparam logic [7:0] OFF_DRV_FEAT_SEL   = 8'h24;
    localparam logic [7:0] OFF_QUEUE_SEL      = 8'h30;
    localparam logic [7:0] OFF_QUEUE_NUM_MAX  = 8'h34;
    localparam logic [7:0] OFF_QUEUE_NUM      = 8'h38;
    localparam logic [7:0] OFF_QUEUE_READY    = 8'h44;
    localparam logic [7:0] OFF_QUEUE_NOTIFY   = 8'h50;
    localparam logic [7:0] OFF_IRQ_STATUS     = 8'h60;
    localparam logic [7:0] OFF_IRQ_ACK        = 8'h64;
    localparam logic [7:0] OFF_STATUS         = 8'h70;
    localparam logic [7:0] OFF_DESC_LO        = 8'h80;
    localparam logic [7:0] OFF_DESC_HI        = 8'h84;
    localparam logic [7:0] OFF_AVAIL_LO       = 8'h90;
    localparam logic [7:0] OFF_AVAIL_HI       = 8'h94;
    localparam logic [7:0] OFF_USED_LO        = 8'hA0;
    localparam logic [7:0] OFF_USED_HI        = 8'hA4;

    // The config space starts here; it is 16 bytes long.
    localparam logic [31:0] CFG_SPACE_BASE = 32'h0000_0100;
    localparam logic [7:0]  CFG_BLK_SIZE_BYTE = 8'd128;

    // Identification words.
    localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE = 32'd2;
    localparam logic [31:0] DEVICE_ID_BLK = 32'd2;

    // Device feature words: version 1 in the high word, flush and read-only low.
    localparam logic [31:0] FEAT_HI_WORD  = 32'h0000_0001;
    localparam logic [31:0] FEAT_LO_FLUSH = 32'h0000_0200;
    localparam logic [31:0] FEAT_LO_RO    = 32'h0000_0020;

    // Access length that register accesses require.
    localparam logic [3:0] REG_ACCESS_LEN = 4'd4;

    // Operation that stage one applies to the queue memory.
    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_SIZE,
        MOP_DESC_LO,
        MOP_DESC_HI,
        MOP_AVAIL_LO,
        MOP_AVAIL_HI,
        MOP_USED_LO,
        MOP_USED_HI,
        MOP_NOTIFY
    } mem_op_t;

endpackage

// ----- hw/rtl/vmmio_ifc.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the virtio-mmio register front end.

// Bus access channel.
interface vmmio_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] address;
    logic [3:0]  access_len;
    logic [31:0] write_data;

    modport source (output valid, func, address, access_len, write_data, input ready);
    modport sink   (input valid, func, address, access_len, write_data, output ready);
endinterface

// Result channel: read data and the notify event.
interface vmmio_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic        notify_valid;
    logic [2:0]  notify_queue;
    logic [8:0]  notify_size;
    logic [63:0] notify_desc_addr;
    logic [63:0] notify_avail_addr;
    logic [63:0] notify_used_addr;
    logic        irq_pulse;

    modport source (output valid, read_data, notify_valid, notify_queue, notify_size,
                    notify_desc_addr, notify_avail_addr, notify_used_addr, irq_pulse,
                    input ready);
    modport sink   (input valid, read_data, notify_valid, notify_queue, notify_size,
                    notify_desc_addr, notify_avail_addr, notify_used_addr, irq_pulse,
                    output ready);
endinterface

// Configuration write channel.
interface vmmio_cfg_if import vmmio_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/virtio_mmio_block_register_front_end_unit.sv -----
`timescale 1ns / 1ps
// virtio-mmio block device register front end: decode, register file and queue memory.
//
// Usage:
//   req carries one bus access per transfer (func, address, access_len,
//   write_data). Every access produces exactly one transfer on rsp, in order:
//   read data for reads, and a notify event with the queue's settings and an
//   interrupt pulse when a ready queue is notified. cfg takes writes of the
//   window base, read-only flag, capacity and vendor word; it is always ready
//   and must only be written while the block is idle.
// Pipeline and throughput:
//   A result passes from stage one into the output register and is presented
//   on rsp from there. One access is taken per cycle while rsp is not stalled:
//   queue settings live in a memory with a registered read, written back by
//   stage one, with forwarding for back-to-back access.
// Stalls:
//   While rsp is stalled the pending result holds; one more access is taken
//   into stage one, after which req.ready drops until rsp takes a transfer.
// Reset:
//   rst_n clears all state at once, with no clearing pass; queue 0 then has the maximum
//   size. A status write of zero clears the device and queue state, queue 0 size too, but not cfg.
module virtio_mmio_block_register_front_end_unit
    import vmmio_pkg::*;
#(
    parameter int MAX_QUEUE_SIZE = 256,
    parameter int NUM_QUEUES     = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    vmmio_req_if.sink         req,
    vmmio_rsp_if.source       rsp,
    vmmio_cfg_if.sink         cfg
);

    localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SIZE_W = $clog2(MAX_QUEUE_SIZE + 1);

    // One queue memory entry.
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [63:0]       desc;
        logic [63:0]       avail;
        logic [63:0]       used;
    } qent_t;

    // Configuration registers.
    logic [63:0] window_base_reg;
    logic        read_only_reg;
    logic [54:0] capacity_reg;
    logic [31:0] vendor_reg;

    // Device register state.
    logic [31:0]           status_reg;
    logic                  irq_pending_reg;
    logic [31:0]           dev_feat_sel_reg;
    logic [31:0]           drv_feat_sel_reg;
    logic [63:0]           drv_feat_reg;
    logic [QSEL_W-1:0]     queue_select_reg;
    logic [NUM_QUEUES-1:0] queue_ready_reg;
    logic [NUM_QUEUES-1:0] ent_valid_reg;
    logic                  q0_max_reg;

    // Queue memory and its read port.
    qent_t qmem [NUM_QUEUES];
    qent_t mem_rd_reg;
    logic  fwd_hit_reg;
    qent_t fwd_data_reg;

    // Stage one.
    logic              s1_valid_reg;
    mem_op_t           s1_op_reg;
    logic [QSEL_W-1:0] s1_addr_reg;
    logic [31:0]       s1_val_reg;
    logic [63:0]       s1_rdata_reg;

    // Output register.
    logic        out_valid_reg;
    logic [63:0] out_rdata_reg;
    logic        out_notify_reg;
    logic [2:0]  out_queue_reg;
    logic [8:0]  out_size_reg;
    logic [63:0] out_desc_reg;
    logic [63:0] out_avail_reg;
    logic [63:0] out_used_reg;

    // Stage zero decode.
    logic [31:0]       s0_off;
    logic [7:0]        s0_off8;
    logic              s0_is_reg;
    logic              s0_wr_ok;
    logic [31:0]       s0_val;
    logic              s0_val_in_range;
    logic              s0_notify_hit;
    logic              s0_size_ok;
    mem_op_t           s0_op;
    logic [QSEL_W-1:0] s0_raddr;
    logic [31:0]       s0_reg_rdata;
    logic [63:0]       s0_rdata;
    logic [127:0]      cfg_space;
    logic [127:0]      cfg_shift;
    logic [31:0]       cfg_rel;

    // Handshake and write-back control.
    logic  accept;
    logic  s1_fire;
    logic  mem_we;
    logic  soft_rst;
    qent_t s1_base;
    qent_t s1_new;

    // Pipeline flow: stage one moves when the output register is free or drains.
    assign accept    = req.valid && req.ready;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign cfg.ready = 1'b1;

    // Window offset and register decode.
    assign s0_off          = req.address[31:0] - window_base_reg[31:0];
    assign s0_off8         = s0_off[7:0];
    assign s0_is_reg       = (s0_off[31:8] == 24'd0);
    assign s0_val          = req.write_data;
    assign s0_wr_ok        = req.func && s0_is_reg && (req.access_len == REG_ACCESS_LEN);
    assign s0_val_in_range = (s0_val < 32'(NUM_QUEUES));
    assign s0_notify_hit   = s0_val_in_range && queue_ready_reg[s0_val[QSEL_W-1:0]];
    assign s0_size_ok      = (s0_val != 32'd0) && (s0_val <= 32'(MAX_QUEUE_SIZE));
    assign soft_rst        = accept && s0_wr_ok && (s0_off8 == OFF_STATUS)
                             && (s0_val == 32'd0);

    // Select the queue memory operation for stage one.
    always_comb
    begin
        s0_op    = MOP_NONE;
        s0_raddr = queue_select_reg;
        if (s0_wr_ok)
        begin
            unique case (s0_off8)
                OFF_QUEUE_NUM:
                begin
                    if (s0_size_ok)
                    begin
                        s0_op = MOP_SIZE;
                    end
                end
                OFF_QUEUE_NOTIFY:
                begin
                    if (s0_notify_hit)
                    begin
                        s0_op    = MOP_NOTIFY;
                        s0_raddr = s0_val[QSEL_W-1:0];
                    end
                end
                OFF_DESC_LO:  s0_op = MOP_DESC_LO;
                OFF_DESC_HI:  s0_op = MOP_DESC_HI;
                OFF_AVAIL_LO: s0_op = MOP_AVAIL_LO;
                OFF_AVAIL_HI: s0_op = MOP_AVAIL_HI;
                OFF_USED_LO:  s0_op = MOP_USED_LO;
                OFF_USED_HI:  s0_op = MOP_USED_HI;
                default:      s0_op = MOP_NONE;
            endcase
        end
    end

    // Register read mux.
    always_comb
    begin
        unique case (s0_off8)
            OFF_MAGIC:         s0_reg_rdata = MAGIC_VALUE;
            OFF_VERSION:       s0_reg_rdata = VERSION_VALUE;
            OFF_DEVICE_ID:     s0_reg_rdata = DEVICE_ID_BLK;
            OFF_VENDOR_ID:     s0_reg_rdata = vendor_reg;
            OFF_DEV_FEAT:
            begin
                if (dev_feat_sel_reg == 32'd1)
                begin
                    s0_reg_rdata = FEAT_HI_WORD;
                end
                else
                begin
                    s0_reg_rdata = FEAT_LO_FLUSH | (read_only_reg ? FEAT_LO_RO : 32'd0);
                end
            end
            OFF_QUEUE_NUM_MAX: s0_reg_rdata = 32'(MAX_QUEUE_SIZE);
            OFF_QUEUE_READY:   s0_reg_rdata = {31'd0, queue_ready_reg[queue_select_reg]};
            OFF_IRQ_STATUS:    s0_reg_rdata = {31'd0, irq_pending_reg};
            OFF_STATUS:        s0_reg_rdata = status_reg;
            default:           s0_reg_rdata = 32'd0;
        endcase
    end

    // Config space: capacity, a zero word and the block size byte, shifted to the offset.
    assign cfg_space = {24'd0, CFG_BLK_SIZE_BYTE, 32'd0, 9'd0, capacity_reg};
    assign cfg_rel   = s0_off - CFG_SPACE_BASE;
    assign cfg_shift = cfg_space >> {cfg_rel[3:0], 3'b000};

    // Read data: registers at length four, config bytes up to the access length.
    always_comb
    begin
        s0_rdata = 64'd0;
        if (!req.func)
        begin
            if (s0_is_reg)
            begin
                if (req.access_len == REG_ACCESS_LEN)
                begin
                    s0_rdata = {32'd0, s0_reg_rdata};
                end
            end
            else if (cfg_rel[31:4] == 28'd0)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    if (4'(i) < req.access_len)
                    begin
                        s0_rdata[8*i +: 8] = cfg_shift[8*i +: 8];
                    end
                end
            end
        end
    end

    // Configuration writes and the scalar device registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg  <= 64'd0;
            read_only_reg    <= 1'b0;
            capacity_reg     <= 55'd0;
            vendor_reg       <= 32'd0;
            status_reg       <= 32'd0;
            irq_pending_reg  <= 1'b0;
            dev_feat_sel_reg <= 32'd0;
            drv_feat_sel_reg <= 32'd0;
            drv_feat_reg     <= 64'd0;
            queue_select_reg <= '0;
            queue_ready_reg  <= '0;
            ent_valid_reg    <= '0;
            q0_max_reg       <= 1'b1;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_WINDOW_BASE: window_base_reg <= cfg.data;
                    CFG_READ_ONLY:   read_only_reg   <= cfg.data[0];
                    CFG_CAPACITY:    capacity_reg    <= cfg.data[54:0];
                    CFG_VENDOR:      vendor_reg      <= cfg.data[31:0];
                    default:         ;
                endcase
            end

            if (accept && s0_wr_ok)
            begin
                unique case (s0_off8)
                    OFF_DEV_FEAT_SEL: dev_feat_sel_reg <= s0_val;
                    OFF_DRV_FEAT_SEL: drv_feat_sel_reg <= s0_val;
                    OFF_DRV_FEAT:
                    begin
                        if (drv_feat_sel_reg == 32'd0)
                        begin
                            drv_feat_reg[31:0] <= s0_val;
                        end
                        else
                        begin
                            drv_feat_reg[63:32] <= s0_val;
                        end
                    end
                    OFF_QUEUE_SEL:
                    begin
                        if (s0_val_in_range)
                        begin
                            queue_select_reg <= s0_val[QSEL_W-1:0];
                        end
                    end
                    OFF_QUEUE_READY:
                    begin
                        queue_ready_reg[queue_select_reg] <= (s0_val != 32'd0);
                    end
                    OFF_QUEUE_NOTIFY:
                    begin
                        if (s0_notify_hit)
                        begin
                            irq_pending_reg <= 1'b1;
                        end
                    end
                    OFF_IRQ_ACK:
                    begin
                        irq_pending_reg <= irq_pending_reg & ~s0_val[0];
                    end
                    OFF_STATUS:
                    begin
                        if (s0_val == 32'd0)
                        begin
                            status_reg       <= 32'd0;
                            irq_pending_reg  <= 1'b0;
                            dev_feat_sel_reg <= 32'd0;
                            drv_feat_sel_reg <= 32'd0;
                            drv_feat_reg     <= 64'd0;
                            queue_select_reg <= '0;
                            queue_ready_reg  <= '0;
                            q0_max_reg       <= 1'b0;
                        end
                        else
                        begin
                            status_reg <= s0_val;
                        end
                    end
                    default: ;
                endcase
            end

            // A soft reset clears every entry; otherwise a written entry becomes valid.
            if (soft_rst)
            begin
                ent_valid_reg <= '0;
            end
            else if (mem_we)
            begin
                ent_valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    // Stage one control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= mem_we && (s1_addr_reg == s0_raddr);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Stage one payload, loaded on a transfer into it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= s0_op;
            s1_addr_reg  <= s0_raddr;
            s1_val_reg   <= s0_val;
            s1_rdata_reg <= s0_rdata;
            fwd_data_reg <= s1_new;
        end
    end

    // Queue memory: registered read at accept, write-back from stage one.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            qmem[s1_addr_reg] <= s1_new;
        end
        if (accept)
        begin
            mem_rd_reg <= qmem[s0_raddr];
        end
    end

    // Current entry: forwarded, stored, or the reset value for an unwritten entry.
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            s1_base = fwd_data_reg;
        end
        else if (ent_valid_reg[s1_addr_reg])
        begin
            s1_base = mem_rd_reg;
        end
        else
        begin
            s1_base       = '0;
            s1_base.size  = ((s1_addr_reg == '0) && q0_max_reg) ?
                            SIZE_W'(MAX_QUEUE_SIZE) : '0;
        end
    end

    // Modify the selected field.
    always_comb
    begin
        s1_new = s1_base;
        unique case (s1_op_reg)
            MOP_SIZE:     s1_new.size        = s1_val_reg[SIZE_W-1:0];
            MOP_DESC_LO:  s1_new.desc[31:0]  = s1_val_reg;
            MOP_DESC_HI:  s1_new.desc[63:32] = s1_val_reg;
            MOP_AVAIL_LO: s1_new.avail[31:0]  = s1_val_reg;
            MOP_AVAIL_HI: s1_new.avail[63:32] = s1_val_reg;
            MOP_USED_LO:  s1_new.used[31:0]  = s1_val_reg;
            MOP_USED_HI:  s1_new.used[63:32] = s1_val_reg;
            default:      ;
        endcase
    end

    assign mem_we = s1_fire && s1_valid_reg && (s1_op_reg != MOP_NONE)
                    && (s1_op_reg != MOP_NOTIFY);

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: notify fields are zero unless a ready queue was notified.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_rdata_reg  <= s1_rdata_reg;
            out_notify_reg <= (s1_op_reg == MOP_NOTIFY);
            if (s1_op_reg == MOP_NOTIFY)
            begin
                out_queue_reg <= 3'(s1_addr_reg);
                out_size_reg  <= 9'(s1_base.size);
                out_desc_reg  <= s1_base.desc;
                out_avail_reg <= s1_base.avail;
                out_used_reg  <= s1_base.used;
            end
            else
            begin
                out_queue_reg <= 3'd0;
                out_size_reg  <= 9'd0;
                out_desc_reg  <= 64'd0;
                out_avail_reg <= 64'd0;
                out_used_reg  <= 64'd0;
            end
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = out_rdata_reg;
    assign rsp.notify_valid      = out_notify_reg;
    assign rsp.notify_queue      = out_queue_reg;
    assign rsp.notify_size       = out_size_reg;
    assign rsp.notify_desc_addr  = out_desc_reg;
    assign rsp.notify_avail_addr = out_avail_reg;
    assign rsp.notify_used_addr  = out_used_reg;
    assign rsp.irq_pulse         = out_notify_reg;

`ifndef SYNTHESIS
    // The bus side only stalls when both stage one and the output register are held.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !rsp.ready))
        else $error("req.ready low without a full, stalled pipeline");

    // A soft reset leaves no queue ready and no queue entry valid.
    a_soft_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        soft_rst |=> (queue_ready_reg == '0) && (ent_valid_reg == '0))
        else $error("soft reset left queue state behind");

    // The queue select never points past the last queue.
    a_queue_select_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(queue_select_reg) < 32'(NUM_QUEUES))
        else $error("queue select out of range");

    // Without a notify the size, descriptor and used addresses and irq pulse of a result are zero.
    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.notify_valid) |->
            (rsp.notify_size == 9'd0) && (rsp.notify_desc_addr == 64'd0)
            && (rsp.notify_used_addr == 64'd0) && !rsp.irq_pulse)
        else $error("event fields set on a result without notify");
`endif

endmodule
